// ===== rtl/trqs_pkg.sv =====
package trqs_pkg;

    // Field widths of the command and result transfers
    localparam int KIND_W   = 2;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int STATE_W  = 2;
    localparam int ACT_W    = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default sizes
    localparam int DEF_NUM_TASKS  = 8;
    localparam int DEF_NUM_LEVELS = 8;
    localparam int DEF_LIST_DEPTH = 8;

    // Task entry in the control memory: ready flag over activation count
    localparam int TASK_ENT_W = ACT_W + 1;

    // Configuration reset values
    localparam logic [23:0] RST_TASK_PRIORITIES = 24'h000000;
    localparam logic [31:0] RST_MAX_ACTIVATIONS = 32'h11111111;
    localparam logic [7:0]  RST_EXTENDED_MASK   = 8'h00;
    localparam logic [7:0]  RST_PREEMPTIVE_MASK = 8'hFF;
    localparam logic [31:0] RST_LIST_LENGTHS    = 32'h88888888;

    typedef logic [ID_W-1:0]  task_id_t;
    typedef logic [ACT_W-1:0] act_cnt_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACTIVATE  = 2'd0,
        KIND_TERMINATE = 2'd1,
        KIND_GET_NEXT  = 2'd2,
        KIND_GET_STATE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LIMIT  = 2'd1,
        STATUS_BAD_ID = 2'd2
    } status_t;

    typedef enum logic [STATE_W-1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_INVALID   = 2'd2
    } task_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TASK_PRIORITIES = 3'd0,
        REG_MAX_ACTIVATIONS = 3'd1,
        REG_EXTENDED_MASK   = 3'd2,
        REG_PREEMPTIVE_MASK = 3'd3,
        REG_LIST_LENGTHS    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        kind_t    kind;
        task_id_t task_id;
        task_id_t running_task;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        task_id_t    next_task;
        task_state_t task_state;
        logic        reschedule;
    } result_t;

    typedef struct packed {
        logic [23:0] task_priorities;
        logic [31:0] max_activations;
        logic [7:0]  extended_mask;
        logic [7:0]  preemptive_mask;
        logic [31:0] list_lengths;
    } cfg_regs_t;

    // Pick field idx of w bits (w up to 4) from a packed word; beyond the word reads zero
    function automatic logic [3:0] pick(logic [63:0] word, logic [6:0] idx, logic [2:0] w);
        logic [9:0]  sh;
        logic [63:0] s;
        sh = 10'(idx) * 10'(w);
        s  = word >> sh;
        return s[3:0] & ~(4'hF << w);
    endfunction

endpackage

// ===== rtl/task_ready_queue_scheduler.sv =====
// Channel   Handshake                 Payload                 Transfer
// -------   -----------------------   ---------------------   --------------------------
// command   start / busy              cmd (cmd_t)             start high, busy low
// result    done strobe               result (result_t)       every cycle done is high
// config    cfg_valid / cfg_ready     cfg_index, cfg_data     cfg_valid and cfg_ready high
//
// Get-next, get-state and commands with a bad id go straight to the query reads; a valid
// activate or terminate first reads and updates the task and level entries and brings the
// ring position back inside the ring. One read port on the control memory orders the accesses:
// task, level, query and head reads in turn. A new command is taken in the cycle that done
// is high. No clearing pass after reset: valid bits make unwritten control entries read as
// zero. Results cannot be stalled.
module task_ready_queue_scheduler #(
    parameter int NUM_TASKS  = trqs_pkg::DEF_NUM_TASKS,
    parameter int NUM_LEVELS = trqs_pkg::DEF_NUM_LEVELS,
    parameter int LIST_DEPTH = trqs_pkg::DEF_LIST_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  trqs_pkg::cmd_t                      cmd,
    output logic                                done,
    output trqs_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trqs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    trqs_pkg::cfg_regs_t cfg_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.task_priorities <= trqs_pkg::RST_TASK_PRIORITIES;
            cfg_reg.max_activations <= trqs_pkg::RST_MAX_ACTIVATIONS;
            cfg_reg.extended_mask   <= trqs_pkg::RST_EXTENDED_MASK;
            cfg_reg.preemptive_mask <= trqs_pkg::RST_PREEMPTIVE_MASK;
            cfg_reg.list_lengths    <= trqs_pkg::RST_LIST_LENGTHS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (trqs_pkg::cfg_reg_t'(cfg_index))
                trqs_pkg::REG_TASK_PRIORITIES: cfg_reg.task_priorities <= cfg_data[23:0];
                trqs_pkg::REG_MAX_ACTIVATIONS: cfg_reg.max_activations <= cfg_data;
                trqs_pkg::REG_EXTENDED_MASK:   cfg_reg.extended_mask   <= cfg_data[7:0];
                trqs_pkg::REG_PREEMPTIVE_MASK: cfg_reg.preemptive_mask <= cfg_data[7:0];
                trqs_pkg::REG_LIST_LENGTHS:    cfg_reg.list_lengths    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    trqs_core #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .done   (done),
        .result (result)
    );

endmodule

// ===== rtl/trqs_ram.sv =====
module trqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/trqs_core.sv =====
module trqs_core #(
    parameter int NUM_TASKS  = trqs_pkg::DEF_NUM_TASKS,
    parameter int NUM_LEVELS = trqs_pkg::DEF_NUM_LEVELS,
    parameter int LIST_DEPTH = trqs_pkg::DEF_LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  trqs_pkg::cmd_t      cmd,
    input  trqs_pkg::cfg_regs_t cfg,
    output logic                done,
    output trqs_pkg::result_t   result
);

    localparam int TW      = $clog2(NUM_TASKS);
    localparam int LW      = $clog2(NUM_LEVELS);
    localparam int PW      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW      = $clog2(LIST_DEPTH + 1);
    localparam int XW      = CW + 1;
    localparam int LVL_W   = PW + CW;
    localparam int ENT_W   = (LVL_W > trqs_pkg::TASK_ENT_W) ? LVL_W : trqs_pkg::TASK_ENT_W;
    localparam int CDEPTH  = NUM_TASKS + NUM_LEVELS;
    localparam int CAW     = $clog2(CDEPTH);
    localparam int RDEPTH  = NUM_LEVELS * LIST_DEPTH;
    localparam int RAW     = $clog2(RDEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TASK,
        S_RD_LVL,
        S_DECIDE,
        S_WRAP,
        S_WR_RING,
        S_WR_TASK,
        S_RD_QUERY,
        S_RD_HEAD,
        S_RD_SLOT,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    trqs_pkg::cmd_t      cmd_reg;
    trqs_pkg::task_id_t  subj_reg;
    logic                id_ok_reg;
    logic                run_ok_reg;
    trqs_pkg::status_t   status_reg;
    logic                resched_reg;
    logic [LW-1:0]       lvl_reg;
    logic [CW-1:0]       len_reg;
    logic                tready_reg;
    trqs_pkg::act_cnt_t  tcnt_reg;
    logic [PW-1:0]       head_reg;
    logic [CW-1:0]       lcnt_reg;
    logic                enq_reg;
    logic                pop_reg;
    logic                twr_reg;
    logic                tready_new_reg;
    trqs_pkg::act_cnt_t  tcnt_new_reg;
    logic [XW-1:0]       wrap_reg;
    logic [LW-1:0]       top_reg;
    logic                any_reg;
    logic                qready_reg;
    logic [CDEPTH-1:0]   ctrl_vld_reg;
    logic                rd_vld_reg;
    logic [NUM_LEVELS-1:0] ne_reg;
    logic                done_reg;
    trqs_pkg::result_t   result_reg;

    // Memory ports
    logic               ctrl_we;
    logic [CAW-1:0]     ctrl_waddr;
    logic [ENT_W-1:0]   ctrl_wdata;
    logic [CAW-1:0]     ctrl_raddr;
    logic [ENT_W-1:0]   ctrl_rdata;
    logic [ENT_W-1:0]   ctrl_q;
    logic               ring_we;
    logic [RAW-1:0]     ring_waddr;
    logic [RAW-1:0]     ring_raddr;
    logic [TW-1:0]      ring_rdata;

    // Decode and decision signals
    logic [2:0]          prio_c;
    logic [3:0]          field_c;
    logic [3:0]          lenf_c;
    logic [LW-1:0]       pcl_c;
    logic [LW-1:0]       lvl_c;
    logic [CW-1:0]       len_c;
    trqs_pkg::act_cnt_t  maxact_c;
    logic                ext_c;
    logic                pre_c;
    logic                modify_c;
    logic [PW-1:0]       lhead_c;
    logic [CW-1:0]       lcnt_c;
    trqs_pkg::status_t   dec_status;
    logic                dec_enq;
    logic                dec_pop;
    logic                dec_twr;
    logic                dec_ready;
    trqs_pkg::act_cnt_t  dec_cnt;
    logic                dec_resched;
    logic [XW-1:0]       dec_wrap;
    logic [CW-1:0]       new_lcnt;
    logic [PW-1:0]       new_head;
    logic [LW-1:0]       top_c;
    logic [CAW-1:0]      lvl_base;

    trqs_ram #(.WIDTH(ENT_W), .DEPTH(CDEPTH)) u_ctrl_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (ctrl_waddr),
        .wdata (ctrl_wdata),
        .raddr (ctrl_raddr),
        .rdata (ctrl_rdata)
    );

    trqs_ram #(.WIDTH(TW), .DEPTH(RDEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (TW'(subj_reg)),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // Entries never written read as zero
    assign ctrl_q  = rd_vld_reg ? ctrl_rdata : '0;
    assign lhead_c = ctrl_q[LVL_W-1:CW];
    assign lcnt_c  = ctrl_q[CW-1:0];
    assign lvl_base = CAW'(NUM_TASKS);

    // Map the subject task to its level and ring length
    always_comb
    begin
        field_c = trqs_pkg::pick(64'(cfg.task_priorities), 7'(subj_reg), 3'd3);
        prio_c  = field_c[2:0];
        if (int'(prio_c) > NUM_LEVELS - 1)
        begin
            pcl_c = LW'(NUM_LEVELS - 1);
        end
        else
        begin
            pcl_c = LW'(prio_c);
        end
        lvl_c  = LW'(NUM_LEVELS - 1) - pcl_c;
        lenf_c = trqs_pkg::pick(64'(cfg.list_lengths), 7'(pcl_c), 3'd4);
        if (lenf_c == 4'd0)
        begin
            len_c = CW'(1);
        end
        else if (int'(lenf_c) > LIST_DEPTH)
        begin
            len_c = CW'(LIST_DEPTH);
        end
        else
        begin
            len_c = CW'(lenf_c);
        end
    end

    // Per-task configuration bits
    always_comb
    begin
        maxact_c = trqs_pkg::pick(64'(cfg.max_activations), 7'(subj_reg), 3'd4);
        ext_c    = trqs_pkg::pick(64'(cfg.extended_mask), 7'(subj_reg), 3'd1) != 4'd0;
        pre_c    = trqs_pkg::pick(64'(cfg.preemptive_mask), 7'(cmd_reg.running_task), 3'd1)
                   != 4'd0;
    end

    // Decide the update from the task entry and the level entry
    always_comb
    begin
        dec_status  = trqs_pkg::STATUS_OK;
        dec_enq     = 1'b0;
        dec_pop     = 1'b0;
        dec_twr     = 1'b0;
        dec_ready   = tready_reg;
        dec_cnt     = tcnt_reg;
        dec_resched = 1'b0;
        if (cmd_reg.kind == trqs_pkg::KIND_ACTIVATE)
        begin
            if (!tready_reg)
            begin
                dec_enq   = 1'b1;
                dec_ready = 1'b1;
                dec_cnt   = (tcnt_reg == '1) ? tcnt_reg : tcnt_reg + 4'd1;
            end
            else if (ext_c)
            begin
                dec_status = trqs_pkg::STATUS_LIMIT;
            end
            else if (tcnt_reg < maxact_c)
            begin
                dec_enq = 1'b1;
                dec_cnt = tcnt_reg + 4'd1;
            end
            else
            begin
                dec_status = trqs_pkg::STATUS_LIMIT;
            end
            // Refuse when the ring is full
            if (dec_enq && (lcnt_c >= len_reg))
            begin
                dec_enq    = 1'b0;
                dec_status = trqs_pkg::STATUS_LIMIT;
            end
            dec_twr     = dec_enq;
            dec_resched = dec_enq && run_ok_reg && pre_c;
        end
        else
        begin
            dec_cnt   = (tcnt_reg != 4'd0) ? tcnt_reg - 4'd1 : tcnt_reg;
            dec_ready = dec_cnt != 4'd0;
            dec_twr   = 1'b1;
            dec_pop   = lcnt_c != '0;
        end
        if (dec_enq)
        begin
            dec_wrap = XW'(lhead_c) + XW'(lcnt_c);
        end
        else
        begin
            dec_wrap = XW'(lhead_c) + XW'(1);
        end
    end

    // New level entry after push or pop
    always_comb
    begin
        if (enq_reg)
        begin
            new_lcnt = lcnt_reg + CW'(1);
            new_head = head_reg;
        end
        else
        begin
            new_lcnt = lcnt_reg - CW'(1);
            new_head = PW'(wrap_reg);
        end
    end

    // Highest-priority non-empty level
    always_comb
    begin
        top_c = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (ne_reg[i])
            begin
                top_c = LW'(i);
            end
        end
    end

    assign modify_c = ((cmd.kind == trqs_pkg::KIND_ACTIVATE) &&
                       (int'(cmd.task_id) < NUM_TASKS)) ||
                      ((cmd.kind == trqs_pkg::KIND_TERMINATE) &&
                       (int'(cmd.running_task) < NUM_TASKS));

    // Next state and memory access
    always_comb
    begin
        state_next = state_reg;
        ctrl_we    = 1'b0;
        ctrl_waddr = '0;
        ctrl_wdata = '0;
        ctrl_raddr = '0;
        ring_we    = 1'b0;
        ring_waddr = RAW'(lvl_reg) * RAW'(LIST_DEPTH) + RAW'(wrap_reg);
        ring_raddr = RAW'(top_reg) * RAW'(LIST_DEPTH) + RAW'(lhead_c);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = modify_c ? S_RD_TASK : S_RD_QUERY;
                end
            end
            S_RD_TASK:
            begin
                ctrl_raddr = CAW'(subj_reg);
                state_next = S_RD_LVL;
            end
            S_RD_LVL:
            begin
                ctrl_raddr = lvl_base + CAW'(lvl_reg);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (wrap_reg < XW'(len_reg))
                begin
                    state_next = S_WR_RING;
                end
            end
            S_WR_RING:
            begin
                ring_we    = enq_reg;
                ctrl_we    = enq_reg || pop_reg;
                ctrl_waddr = lvl_base + CAW'(lvl_reg);
                ctrl_wdata = ENT_W'({new_head, new_lcnt});
                state_next = S_WR_TASK;
            end
            S_WR_TASK:
            begin
                ctrl_we    = twr_reg;
                ctrl_waddr = CAW'(subj_reg);
                ctrl_wdata = ENT_W'({tready_new_reg, tcnt_new_reg});
                state_next = S_RD_QUERY;
            end
            S_RD_QUERY:
            begin
                ctrl_raddr = id_ok_reg ? CAW'(cmd_reg.task_id) : '0;
                state_next = S_RD_HEAD;
            end
            S_RD_HEAD:
            begin
                ctrl_raddr = lvl_base + CAW'(top_reg);
                state_next = S_RD_SLOT;
            end
            S_RD_SLOT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            subj_reg       <= '0;
            id_ok_reg      <= 1'b0;
            run_ok_reg     <= 1'b0;
            status_reg     <= trqs_pkg::STATUS_OK;
            resched_reg    <= 1'b0;
            lvl_reg        <= '0;
            len_reg        <= '0;
            tready_reg     <= 1'b0;
            tcnt_reg       <= '0;
            head_reg       <= '0;
            lcnt_reg       <= '0;
            enq_reg        <= 1'b0;
            pop_reg        <= 1'b0;
            twr_reg        <= 1'b0;
            tready_new_reg <= 1'b0;
            tcnt_new_reg   <= '0;
            wrap_reg       <= '0;
            top_reg        <= '0;
            any_reg        <= 1'b0;
            qready_reg     <= 1'b0;
            ctrl_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            ne_reg         <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= 1'b0;
            rd_vld_reg <= ctrl_vld_reg[ctrl_raddr];
            if (ctrl_we)
            begin
                ctrl_vld_reg[ctrl_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    // Take a command
                    if (start)
                    begin
                        cmd_reg     <= cmd;
                        subj_reg    <= (cmd.kind == trqs_pkg::KIND_TERMINATE) ?
                                       cmd.running_task : cmd.task_id;
                        id_ok_reg   <= int'(cmd.task_id) < NUM_TASKS;
                        run_ok_reg  <= int'(cmd.running_task) < NUM_TASKS;
                        resched_reg <= 1'b0;
                        if (((cmd.kind == trqs_pkg::KIND_ACTIVATE ||
                              cmd.kind == trqs_pkg::KIND_GET_STATE) &&
                             int'(cmd.task_id) >= NUM_TASKS) ||
                            (cmd.kind == trqs_pkg::KIND_TERMINATE &&
                             int'(cmd.running_task) >= NUM_TASKS))
                        begin
                            status_reg <= trqs_pkg::STATUS_BAD_ID;
                        end
                        else
                        begin
                            status_reg <= trqs_pkg::STATUS_OK;
                        end
                    end
                end
                S_RD_TASK:
                begin
                    lvl_reg <= lvl_c;
                    len_reg <= len_c;
                end
                S_RD_LVL:
                begin
                    tready_reg <= ctrl_q[trqs_pkg::ACT_W];
                    tcnt_reg   <= ctrl_q[trqs_pkg::ACT_W-1:0];
                end
                S_DECIDE:
                begin
                    head_reg       <= lhead_c;
                    lcnt_reg       <= lcnt_c;
                    status_reg     <= dec_status;
                    resched_reg    <= dec_resched;
                    enq_reg        <= dec_enq;
                    pop_reg        <= dec_pop;
                    twr_reg        <= dec_twr;
                    tready_new_reg <= dec_ready;
                    tcnt_new_reg   <= dec_cnt;
                    wrap_reg       <= dec_wrap;
                end
                S_WRAP:
                begin
                    // Reduce the ring position one length per cycle
                    if (wrap_reg >= XW'(len_reg))
                    begin
                        wrap_reg <= wrap_reg - XW'(len_reg);
                    end
                end
                S_WR_RING:
                begin
                    if (enq_reg || pop_reg)
                    begin
                        ne_reg[lvl_reg] <= new_lcnt != '0;
                    end
                end
                S_WR_TASK:
                begin
                end
                S_RD_QUERY:
                begin
                    top_reg <= top_c;
                    any_reg <= |ne_reg;
                end
                S_RD_HEAD:
                begin
                    qready_reg <= ctrl_q[trqs_pkg::ACT_W];
                end
                S_RD_SLOT:
                begin
                end
                S_FINISH:
                begin
                    // Present the result for one cycle
                    done_reg              <= 1'b1;
                    result_reg.status     <= status_reg;
                    result_reg.next_task  <= any_reg ? trqs_pkg::task_id_t'(ring_rdata) :
                                             trqs_pkg::task_id_t'(NUM_TASKS);
                    result_reg.reschedule <= resched_reg;
                    if (!id_ok_reg)
                    begin
                        result_reg.task_state <= trqs_pkg::ST_INVALID;
                    end
                    else if (qready_reg)
                    begin
                        result_reg.task_state <= trqs_pkg::ST_READY;
                    end
                    else
                    begin
                        result_reg.task_state <= trqs_pkg::ST_SUSPENDED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/trqs_sva.sv =====
module trqs_sva (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input trqs_pkg::result_t result
);

    // A transfer starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not raise busy");

    // The result appears as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("done without a finished command");

    // Finishing a command always yields a result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // Result codes stay among the defined ones
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == trqs_pkg::STATUS_OK ||
                  result.status == trqs_pkg::STATUS_LIMIT ||
                  result.status == trqs_pkg::STATUS_BAD_ID) &&
                 (result.task_state == trqs_pkg::ST_SUSPENDED ||
                  result.task_state == trqs_pkg::ST_READY ||
                  result.task_state == trqs_pkg::ST_INVALID))
        else $error("undefined result code");

    // Reschedule only follows a clean activation
    a_resched: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.reschedule |-> result.status == trqs_pkg::STATUS_OK)
        else $error("reschedule with failing status");

endmodule

bind task_ready_queue_scheduler trqs_sva u_trqs_sva (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
